// ----- rtl/vpic_pkg.sv -----
// ----------------------------------------------------------------------------
// vpic_pkg
// types, register indexes and constants shared by the interrupt controller
// ----------------------------------------------------------------------------
package vpic_pkg;

   localparam int NUM_SOURCES = 64;
   localparam int NUM_GROUPS  = NUM_SOURCES / 8;

   localparam logic [31:0] CTRL_WRITE_BITS = 32'h0179_0ffc;
   localparam logic [31:0] CTRL_ABORT_FLAG = 32'h0200_0000;
   localparam logic [4:0]  MASK_ALL        = 5'h1f;

   // command codes
   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_LINE  = 2'd2;

   // register word indexes (byte offset / 4)
   localparam logic [4:0] REG_CTRL     = 5'd0;
   localparam logic [4:0] REG_MASK     = 5'd1;
   localparam logic [4:0] REG_ENA_NUM  = 5'd2;
   localparam logic [4:0] REG_DIS_NUM  = 5'd3;
   localparam logic [4:0] REG_ENA_HI   = 5'd4;
   localparam logic [4:0] REG_ENA_LO   = 5'd5;
   localparam logic [4:0] REG_TYPE_HI  = 5'd6;
   localparam logic [4:0] REG_TYPE_LO  = 5'd7;
   localparam logic [4:0] REG_PRIO_0   = 5'd8;
   localparam logic [4:0] REG_PRIO_7   = 5'd15;
   localparam logic [4:0] REG_NVEC     = 5'd16;
   localparam logic [4:0] REG_FVEC     = 5'd17;
   localparam logic [4:0] REG_LINE_HI  = 5'd18;
   localparam logic [4:0] REG_LINE_LO  = 5'd19;
   localparam logic [4:0] REG_FORCE_HI = 5'd20;
   localparam logic [4:0] REG_FORCE_LO = 5'd21;
   localparam logic [4:0] REG_NPEND_HI = 5'd22;
   localparam logic [4:0] REG_NPEND_LO = 5'd23;
   localparam logic [4:0] REG_FPEND_HI = 5'd24;
   localparam logic [4:0] REG_FPEND_LO = 5'd25;

   typedef struct packed {
      logic [1:0]  command;
      logic [6:0]  register_offset;
      logic [31:0] write_data;
      logic [5:0]  source_number;
   } vpic_req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        irq_asserted;
      logic        fiq_asserted;
      logic        access_error;
   } vpic_rsp_type;

   typedef struct packed {
      logic       capture;
      logic       exec;
      logic       scan_clear;
      logic       scan_en;
      logic [2:0] scan_idx;
      logic       out_load;
   } vpic_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_DONE
   } vpic_state_type;

endpackage

// ----- rtl/vectored_priority_interrupt_controller_unit.sv -----
// ----------------------------------------------------------------------------
// vectored_priority_interrupt_controller_unit
// 64-source vectored priority interrupt controller, one beat in, one beat out
// ----------------------------------------------------------------------------
// each request beat (bus read, bus write or source line change) yields one
// response beat with the read image, the irq/fiq levels after the beat and an
// access error flag. once the beat is accepted there is an execute step, a
// scan that walks the priority registers eight sources at a time to find
// the highest pending normal priority and the highest pending fast index,
// and a load into the response register. the response is offered from the
// next cycle on. a new request is taken once the previous result is loaded,
// even while that result is still stalled at the output; its own load then
// waits until the output is free.
module vectored_priority_interrupt_controller_unit
   import vpic_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  vpic_req_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output vpic_rsp_type rsp_payload
);

   // command bundle from the sequencer to the datapath
   vpic_cmd_type cmd;

   vpic_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   vpic_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- rtl/vpic_ctrl.sv -----
// ----------------------------------------------------------------------------
// vpic_ctrl
// sequencer: capture, execute, eight-group priority scan, result load
// ----------------------------------------------------------------------------
module vpic_ctrl
   import vpic_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output vpic_cmd_type cmd
);

   vpic_state_type state_ff, state_in;
   logic [2:0]     cnt_ff, cnt_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_EXEC;
         ST_EXEC: state_in = ST_SCAN;
         ST_SCAN: if (cnt_ff == 3'(NUM_GROUPS - 1)) state_in = ST_DONE;
         ST_DONE: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.capture    = (state_ff == ST_IDLE) && req_valid;
      cmd.exec       = (state_ff == ST_EXEC);
      cmd.scan_clear = (state_ff == ST_EXEC);
      cmd.scan_en    = (state_ff == ST_SCAN);
      cmd.scan_idx   = cnt_ff;
      cmd.out_load   = (state_ff == ST_DONE) && out_free;
   end

   assign cnt_in       = (state_ff == ST_SCAN) ? cnt_ff + 3'd1 : 3'd0;
   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);
   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/vpic_dp.sv -----
// ----------------------------------------------------------------------------
// vpic_dp
// register file, pending logic, priority scan and result register
// ----------------------------------------------------------------------------
module vpic_dp
   import vpic_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  vpic_cmd_type cmd,
   input  vpic_req_type req_payload,
   output vpic_rsp_type rsp_payload
);

   vpic_req_type req_ff;
   logic [63:0]  lines_ff, force_ff, ena_ff, type_ff;
   logic [31:0]  prio_ff [NUM_GROUPS];
   logic [4:0]   mask_ff;
   logic [31:0]  ctrl_ff;
   logic         err_ff;
   logic         found_ff, fvalid_ff;
   logic [5:0]   best_idx_ff, fidx_ff;
   logic [3:0]   best_lvl_ff;
   vpic_rsp_type out_ff;

   logic [63:0] np, fp;
   logic [4:0]  word;
   logic        aligned;
   logic [31:0] wd;
   logic        num_ok;

   assign np      = (lines_ff | force_ff) & ena_ff & ~type_ff;
   assign fp      = (lines_ff | force_ff) & ena_ff & type_ff;
   assign word    = req_ff.register_offset[6:2];
   assign aligned = (req_ff.register_offset[1:0] == 2'b00);
   assign wd      = req_ff.write_data;
   assign num_ok  = (wd[31:6] == 26'd0);

   // access error of the captured beat
   logic err_calc;
   always_comb begin
      err_calc = 1'b0;
      unique case (req_ff.command)
         CMD_READ:  err_calc = !aligned || (word > REG_FPEND_LO);
         CMD_WRITE: begin
            if (!aligned) err_calc = 1'b1;
            else begin
               unique case (word)
                  REG_ENA_NUM, REG_DIS_NUM: err_calc = !num_ok;
                  REG_CTRL, REG_MASK, REG_ENA_HI, REG_ENA_LO, REG_TYPE_HI,
                  REG_TYPE_LO, REG_FORCE_HI, REG_FORCE_LO: err_calc = 1'b0;
                  default: err_calc = !((word >= REG_PRIO_0) && (word <= REG_PRIO_7));
               endcase
            end
         end
         CMD_LINE:  err_calc = 1'b0;
         default:   err_calc = 1'b1;
      endcase
   end

   // state update
   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_payload;
      if (reset) begin
         lines_ff <= '0;
         force_ff <= '0;
         ena_ff   <= '0;
         type_ff  <= '0;
         mask_ff  <= MASK_ALL;
         ctrl_ff  <= '0;
         for (int g = 0; g < NUM_GROUPS; g++) prio_ff[g] <= '0;
      end else if (cmd.exec) begin
         if (req_ff.command == CMD_LINE) begin
            lines_ff[req_ff.source_number] <= !wd[0];
         end else if (req_ff.command == CMD_WRITE && aligned) begin
            unique case (word)
               REG_CTRL: ctrl_ff <= (wd & CTRL_WRITE_BITS) |
                                    (wd[25] ? 32'd0 : (ctrl_ff & CTRL_ABORT_FLAG));
               REG_MASK:     mask_ff <= wd[4:0];
               REG_ENA_NUM:  if (num_ok) ena_ff[wd[5:0]] <= 1'b1;
               REG_DIS_NUM:  if (num_ok) ena_ff[wd[5:0]] <= 1'b0;
               REG_ENA_HI:   ena_ff[63:32]   <= wd;
               REG_ENA_LO:   ena_ff[31:0]    <= wd;
               REG_TYPE_HI:  type_ff[63:32]  <= wd;
               REG_TYPE_LO:  type_ff[31:0]   <= wd;
               REG_FORCE_HI: force_ff[63:32] <= wd;
               REG_FORCE_LO: force_ff[31:0]  <= wd;
               default: begin
                  if ((word >= REG_PRIO_0) && (word <= REG_PRIO_7))
                     prio_ff[word[2:0]] <= wd;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) err_ff <= err_calc;
   end

   // one group of eight sources per cycle, ascending index
   logic       found_in, fvalid_in;
   logic [5:0] best_idx_in, fidx_in;
   logic [3:0] best_lvl_in;
   logic [7:0] gnp, gfp;
   logic [31:0] gprio;
   always_comb begin
      gnp         = np[{cmd.scan_idx, 3'b000} +: 8];
      gfp         = fp[{cmd.scan_idx, 3'b000} +: 8];
      gprio       = prio_ff[cmd.scan_idx];
      found_in    = found_ff;
      fvalid_in   = fvalid_ff;
      best_idx_in = best_idx_ff;
      best_lvl_in = best_lvl_ff;
      fidx_in     = fidx_ff;
      for (int i = 0; i < 8; i++) begin
         if (gnp[i] && (!found_in || gprio[4*i +: 4] > best_lvl_in)) begin
            found_in    = 1'b1;
            best_idx_in = {cmd.scan_idx, 3'(i)};
            best_lvl_in = gprio[4*i +: 4];
         end
         if (gfp[i]) begin
            fvalid_in = 1'b1;
            fidx_in   = {cmd.scan_idx, 3'(i)};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_clear) begin
         found_ff  <= 1'b0;
         fvalid_ff <= 1'b0;
      end else if (cmd.scan_en) begin
         found_ff    <= found_in;
         fvalid_ff   <= fvalid_in;
         best_idx_ff <= best_idx_in;
         best_lvl_ff <= best_lvl_in;
         fidx_ff     <= fidx_in;
      end
   end

   // read image
   logic [31:0] rd;
   always_comb begin
      rd = 32'd0;
      if (req_ff.command == CMD_READ && aligned) begin
         unique case (word)
            REG_CTRL:     rd = ctrl_ff;
            REG_MASK:     rd = {27'd0, mask_ff};
            REG_ENA_HI:   rd = ena_ff[63:32];
            REG_ENA_LO:   rd = ena_ff[31:0];
            REG_TYPE_HI:  rd = type_ff[63:32];
            REG_TYPE_LO:  rd = type_ff[31:0];
            REG_NVEC:     rd = found_ff ? {10'd0, best_idx_ff, 12'd0, best_lvl_ff} : '1;
            REG_FVEC:     rd = fvalid_ff ? {26'd0, fidx_ff} : '1;
            REG_LINE_HI:  rd = lines_ff[63:32];
            REG_LINE_LO:  rd = lines_ff[31:0];
            REG_FORCE_HI: rd = force_ff[63:32];
            REG_FORCE_LO: rd = force_ff[31:0];
            REG_NPEND_HI: rd = np[63:32];
            REG_NPEND_LO: rd = np[31:0];
            REG_FPEND_HI: rd = fp[63:32];
            REG_FPEND_LO: rd = fp[31:0];
            default: begin
               if ((word >= REG_PRIO_0) && (word <= REG_PRIO_7)) rd = prio_ff[word[2:0]];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_ff.read_data    <= rd;
         out_ff.irq_asserted <= found_ff &&
                                ((mask_ff == MASK_ALL) || ({1'b0, best_lvl_ff} > mask_ff));
         out_ff.fiq_asserted <= (fp != 64'd0);
         out_ff.access_error <= err_ff;
      end
   end

   assign rsp_payload = out_ff;

   a_fiq_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load && (fp != 64'd0) |-> fvalid_ff)
      else $error("fast pending without scanned fast index");
   a_best_pending: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load && found_ff |-> np[best_idx_ff])
      else $error("normal vector names a source that is not pending");
   a_scan_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_clear |=> !found_ff && !fvalid_ff)
      else $error("scan result not cleared");

endmodule
